// ----- rtl/aou_pkg.sv -----
// aou_pkg: shared types, constants and helpers of the adam optimizer update block
// used by aou_front, aou_back, adam_optimizer_update and the testbench; no dependencies
`default_nettype none

package aou_pkg;

  // sizing
  localparam int MAX_PARAMS = 1024;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int CNT_W      = 11;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  // iteration counts of the arithmetic pipeline
  localparam int DIV_STEPS   = 72;
  localparam int SQRT_STEPS  = 52;
  localparam int QDIV_STEPS  = 40;

  // fixed point constants
  localparam logic [24:0] ONE_Q24   = 25'h100_0000;
  localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_STABILITY_TERM = CFG_IDX_W'(4);

  typedef struct packed {
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
  } aou_in_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic [IDX_W-1:0]   element_index;
    logic               step_end;
  } aou_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] param_count;
    logic [23:0]      step_rate;
    logic [23:0]      first_decay;
    logic [23:0]      second_decay;
    logic [31:0]      stability_term;
  } aou_cfg_t;

  // one classified element waiting for the back end
  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] grad;
    logic [IDX_W-1:0]   idx;
    logic               last;
    logic [24:0]        pow1;
    logic [24:0]        pow2;
  } aou_job_t;

  typedef struct packed {
    logic     valid;
    aou_job_t job;
  } aou_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } aou_ctl_t;

  // element count of one step after clamping
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] pc);
    logic [CNT_W-1:0] c;
    c = pc;
    if (pc == '0) begin
      c = CNT_W'(1);
    end else if (pc > CNT_W'(MAX_PARAMS)) begin
      c = CNT_W'(MAX_PARAMS);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/aou_ram.sv -----
// aou_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module aou_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/aou_front.sv -----
// aou_front: accepts input beats, tracks element position and decay powers,
// and queues classified elements for the back end; uses aou_pkg
`default_nettype none

module aou_front (
  input  logic               clk,
  input  logic               rst_n,
  input  aou_pkg::aou_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  aou_pkg::aou_in_t   in_payload,
  output aou_pkg::aou_head_t head,
  input  aou_pkg::aou_ctl_t  ctl
);
  import aou_pkg::*;

  logic [IDX_W-1:0]   elem_cnt_r, elem_cnt_nxt;
  logic [24:0]        pow1_r, pow2_r;
  logic [48:0]        prod1, prod2;
  logic [24:0]        pow1_adv, pow2_adv;
  logic [CNT_W-1:0]   cnt_eff;
  logic               first_elem;
  logic               last;
  logic               accept;
  aou_job_t           job_nxt;

  aou_job_t           q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   q_cnt_r;

  // queue full or memories still clearing
  assign in_stall = (q_cnt_r == (Q_PTR_W+1)'(Q_DEPTH)) | ctl.clearing;
  assign accept   = in_valid & ~in_stall;

  // classify the element: position, end of step, decay powers
  always_comb begin
    cnt_eff      = eff_count(cfg.param_count);
    first_elem   = (elem_cnt_r == '0);
    prod1        = 49'(pow1_r) * 49'(cfg.first_decay);
    prod2        = 49'(pow2_r) * 49'(cfg.second_decay);
    pow1_adv     = prod1[48:24];
    pow2_adv     = prod2[48:24];
    last         = (CNT_W'(elem_cnt_r) + CNT_W'(1)) >= cnt_eff;
    elem_cnt_nxt = last ? '0 : elem_cnt_r + IDX_W'(1);
    job_nxt.weight = in_payload.weight_in;
    job_nxt.grad   = in_payload.gradient;
    job_nxt.idx    = elem_cnt_r;
    job_nxt.last   = last;
    job_nxt.pow1   = first_elem ? pow1_adv : pow1_r;
    job_nxt.pow2   = first_elem ? pow2_adv : pow2_r;
  end

  // position and running powers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= '0;
      pow1_r     <= ONE_Q24;
      pow2_r     <= ONE_Q24;
    end else if (accept) begin
      elem_cnt_r <= elem_cnt_nxt;
      if (first_elem) begin
        pow1_r <= pow1_adv;
        pow2_r <= pow2_adv;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wr_ptr_r] <= job_nxt;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (ctl.pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + (Q_PTR_W+1)'(accept) - (Q_PTR_W+1)'(ctl.pop);
    end
  end

  assign head.valid = (q_cnt_r != '0);
  assign head.job   = q_mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- rtl/aou_back.sv -----
// aou_back: moment memories, moment update and the pipelined bias correction,
// square root and step division; uses aou_pkg and aou_ram
`default_nettype none

module aou_back (
  input  logic               clk,
  input  logic               rst_n,
  input  aou_pkg::aou_cfg_t  cfg,
  input  aou_pkg::aou_head_t head,
  output aou_pkg::aou_ctl_t  ctl,
  output logic               out_valid,
  input  logic               out_stall,
  output aou_pkg::aou_out_t  out_payload
);
  import aou_pkg::*;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] weight;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } sd_t;

  typedef struct packed {
    sd_t                sd;
    logic signed [57:0] c1g;
    logic [47:0]        gsq;
    logic [24:0]        pow1;
    logic [24:0]        pow2;
  } s1_t;

  typedef struct packed {
    sd_t                sd;
    logic signed [57:0] pm1;
    logic signed [57:0] c1g;
    logic [71:0]        pv;
    logic [72:0]        pc2;
    logic [24:0]        pow1;
    logic [24:0]        pow2;
  } s2_t;

  typedef struct packed {
    sd_t         sd;
    logic        neg;
    logic [24:0] d1;
    logic [24:0] d2;
    logic [24:0] r1;
    logic [24:0] r2;
    logic [71:0] n1;
    logic [71:0] n2;
  } dv_t;

  typedef struct packed {
    sd_t         sd;
    logic        neg;
    logic [63:0] vhat;
    logic [51:0] pl;
    logic [51:0] ph;
  } pm_t;

  typedef struct packed {
    sd_t         sd;
    logic        neg;
    logic [79:0] num;
    logic [63:0] rad;
    logic [53:0] rem;
    logic [51:0] root;
  } sq_t;

  typedef struct packed {
    sd_t         sd;
    logic        neg;
    logic        cap;
    logic [52:0] den;
    logic [52:0] rem;
    logic [39:0] low;
  } qd_t;

  // bias correction term, a zero or a value above one reads as one
  function automatic logic [24:0] bias_corr(input logic [24:0] p);
    logic [24:0] bc;
    bc = ONE_Q24 - p;
    if (bc == '0 || bc > ONE_Q24) begin
      bc = 25'd1;
    end
    return bc;
  endfunction

  // one restoring division step on both lanes
  function automatic dv_t div_step(input dv_t a);
    dv_t         b;
    logic [25:0] t1, t2;
    b  = a;
    t1 = {a.r1, a.n1[71]};
    t2 = {a.r2, a.n2[71]};
    if (t1 >= {1'b0, a.d1}) begin
      b.r1 = 25'(t1 - {1'b0, a.d1});
      b.n1 = {a.n1[70:0], 1'b1};
    end else begin
      b.r1 = t1[24:0];
      b.n1 = {a.n1[70:0], 1'b0};
    end
    if (t2 >= {1'b0, a.d2}) begin
      b.r2 = 25'(t2 - {1'b0, a.d2});
      b.n2 = {a.n2[70:0], 1'b1};
    end else begin
      b.r2 = t2[24:0];
      b.n2 = {a.n2[70:0], 1'b0};
    end
    return b;
  endfunction

  // one digit of the restoring square root
  function automatic sq_t sqrt_step(input sq_t a);
    sq_t         b;
    logic [55:0] t;
    logic [55:0] trial;
    b     = a;
    t     = {a.rem, a.rad[63:62]};
    trial = 56'({a.root, 2'b01});
    if (t >= trial) begin
      b.rem  = 54'(t - trial);
      b.root = {a.root[50:0], 1'b1};
    end else begin
      b.rem  = t[53:0];
      b.root = {a.root[50:0], 1'b0};
    end
    b.rad = {a.rad[61:0], 2'b00};
    return b;
  endfunction

  // one quotient bit of the step division, a zero denominator leaves zero bits
  function automatic qd_t qdiv_step(input qd_t a);
    qd_t         b;
    logic [53:0] t;
    b = a;
    t = {a.rem, a.low[39]};
    if (a.den != '0 && t >= 54'(a.den)) begin
      b.rem = 53'(t - 54'(a.den));
      b.low = {a.low[38:0], 1'b1};
    end else begin
      b.rem = t[52:0];
      b.low = {a.low[38:0], 1'b0};
    end
    return b;
  endfunction

  logic               adv;
  logic               hazard;
  logic               pop;
  logic               clearing_r;
  logic [IDX_W-1:0]   clr_addr_r;

  logic [24:0]        c1, c2;
  logic [31:0]        ga;
  logic [63:0]        gsq_full;
  s1_t                s1_r, s1_nxt;
  s2_t                s2_r, s2_nxt;

  logic [31:0]        m_rdata;
  logic [47:0]        v_rdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [31:0]        m_wdata;
  logic [47:0]        v_wdata;

  logic signed [57:0] msum;
  logic signed [31:0] m_new;
  logic [73:0]        vsum;
  logic [47:0]        v_new;
  logic [31:0]        ma;
  dv_t                dv_nxt;
  dv_t                dv_r [DIV_STEPS+1];

  logic [55:0]        mhat;
  pm_t                pm_r, pm_nxt;
  sq_t                sq_nxt;
  sq_t                sq_r [SQRT_STEPS+1];

  logic [47:0]        high;
  logic               sat;
  qd_t                qd_nxt;
  qd_t                qd_r [QDIV_STEPS+1];

  logic [33:0]        delta;
  logic signed [35:0] res;
  logic               out_valid_r;
  aou_out_t           out_r, out_nxt;

  // the whole back end moves when the output register can take a beat
  assign adv = ~out_valid_r | ~out_stall;

  // memory clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(MAX_PARAMS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // issue: wait while an older element of the same index is still updating
  assign hazard = (s1_r.sd.valid & (s1_r.sd.idx == head.job.idx)) |
                  (s2_r.sd.valid & (s2_r.sd.idx == head.job.idx));
  assign pop          = adv & head.valid & ~hazard & ~clearing_r;
  assign ctl.pop      = pop;
  assign ctl.clearing = clearing_r;

  // gradient terms alongside the memory read
  always_comb begin
    c1       = ONE_Q24 - {1'b0, cfg.first_decay};
    ga       = head.job.grad[31] ? 32'(-head.job.grad) : 32'(head.job.grad);
    gsq_full = 64'(ga) * 64'(ga);
    s1_nxt.sd.valid  = pop;
    s1_nxt.sd.weight = head.job.weight;
    s1_nxt.sd.idx    = head.job.idx;
    s1_nxt.sd.last   = head.job.last;
    s1_nxt.c1g       = $signed({1'b0, c1}) * head.job.grad;
    s1_nxt.gsq       = (gsq_full[63:56] != '0) ? '1 : gsq_full[55:8];
    s1_nxt.pow1      = head.job.pow1;
    s1_nxt.pow2      = head.job.pow2;
  end

  aou_ram #(.WIDTH(32), .DEPTH(MAX_PARAMS)) u_m_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (m_wdata),
    .re    (pop),
    .raddr (head.job.idx),
    .rdata (m_rdata)
  );

  aou_ram #(.WIDTH(48), .DEPTH(MAX_PARAMS)) u_v_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (v_wdata),
    .re    (pop),
    .raddr (head.job.idx),
    .rdata (v_rdata)
  );

  // decay products of the old moments
  always_comb begin
    c2          = ONE_Q24 - {1'b0, cfg.second_decay};
    s2_nxt.sd   = s1_r.sd;
    s2_nxt.pm1  = $signed({1'b0, cfg.first_decay}) * $signed(m_rdata);
    s2_nxt.c1g  = s1_r.c1g;
    s2_nxt.pv   = 72'(cfg.second_decay) * 72'(v_rdata);
    s2_nxt.pc2  = 73'(c2) * 73'(s1_r.gsq);
    s2_nxt.pow1 = s1_r.pow1;
    s2_nxt.pow2 = s1_r.pow2;
  end

  // new moments, write back, divider setup
  always_comb begin
    msum  = s2_r.pm1 + s2_r.c1g;
    m_new = msum[55:24];
    vsum  = 74'(s2_r.pv) + 74'(s2_r.pc2);
    v_new = (vsum[73:72] != '0) ? '1 : vsum[71:24];
    ma    = m_new[31] ? 32'(-m_new) : 32'(m_new);
    dv_nxt.sd  = s2_r.sd;
    dv_nxt.neg = m_new[31];
    dv_nxt.d1  = bias_corr(s2_r.pow1);
    dv_nxt.d2  = bias_corr(s2_r.pow2);
    dv_nxt.r1  = '0;
    dv_nxt.r2  = '0;
    dv_nxt.n1  = {16'b0, ma, 24'b0};
    dv_nxt.n2  = {v_new, 24'b0};
  end

  assign mem_we    = clearing_r | (s2_r.sd.valid & adv);
  assign mem_waddr = clearing_r ? clr_addr_r : s2_r.sd.idx;
  assign m_wdata   = clearing_r ? '0 : m_new;
  assign v_wdata   = clearing_r ? '0 : v_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.sd.valid   <= 1'b0;
      s2_r.sd.valid   <= 1'b0;
      dv_r[0].sd.valid <= 1'b0;
    end else if (adv) begin
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      dv_r[0] <= dv_nxt;
    end
  end

  // bias correction dividers, one quotient bit per stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1].sd.valid <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
    end
  end

  // corrected moments and learning rate partial products
  always_comb begin
    mhat        = dv_r[DIV_STEPS].n1[55:0];
    pm_nxt.sd   = dv_r[DIV_STEPS].sd;
    pm_nxt.neg  = dv_r[DIV_STEPS].neg;
    pm_nxt.vhat = (dv_r[DIV_STEPS].n2[71:64] != '0) ? '1 : dv_r[DIV_STEPS].n2[63:0];
    pm_nxt.pl   = 52'(cfg.step_rate) * 52'(mhat[27:0]);
    pm_nxt.ph   = 52'(cfg.step_rate) * 52'(mhat[55:28]);
  end

  // numerator sum and square root setup
  always_comb begin
    sq_nxt.sd   = pm_r.sd;
    sq_nxt.neg  = pm_r.neg;
    sq_nxt.num  = {pm_r.ph, 28'b0} + 80'(pm_r.pl);
    sq_nxt.rad  = pm_r.vhat;
    sq_nxt.rem  = '0;
    sq_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r.sd.valid    <= 1'b0;
      sq_r[0].sd.valid <= 1'b0;
    end else if (adv) begin
      pm_r    <= pm_nxt;
      sq_r[0] <= sq_nxt;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1].sd.valid <= 1'b0;
      end else if (adv) begin
        sq_r[k+1] <= sqrt_step(sq_r[k]);
      end
    end
  end

  // denominator and overflow check of the step quotient
  always_comb begin
    high       = sq_r[SQRT_STEPS].num[79:32];
    qd_nxt.sd  = sq_r[SQRT_STEPS].sd;
    qd_nxt.neg = sq_r[SQRT_STEPS].neg;
    qd_nxt.den = 53'(sq_r[SQRT_STEPS].root) + 53'(cfg.stability_term);
    sat        = 53'(high) >= qd_nxt.den;
    qd_nxt.cap = sat & (sq_r[SQRT_STEPS].num != '0);
    qd_nxt.rem = sat ? '0 : 53'(high);
    qd_nxt.low = {sq_r[SQRT_STEPS].num[31:0], 8'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_r[0].sd.valid <= 1'b0;
    end else if (adv) begin
      qd_r[0] <= qd_nxt;
    end
  end

  // step division, one quotient bit per stage
  for (genvar k = 0; k < QDIV_STEPS; k++) begin : g_qdiv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_r[k+1].sd.valid <= 1'b0;
      end else if (adv) begin
        qd_r[k+1] <= qdiv_step(qd_r[k]);
      end
    end
  end

  // apply the step and saturate
  always_comb begin
    if (qd_r[QDIV_STEPS].cap || qd_r[QDIV_STEPS].low > 40'(DELTA_CAP)) begin
      delta = DELTA_CAP;
    end else begin
      delta = qd_r[QDIV_STEPS].low[33:0];
    end
    if (qd_r[QDIV_STEPS].neg) begin
      res = 36'(qd_r[QDIV_STEPS].sd.weight) + $signed({2'b00, delta});
    end else begin
      res = 36'(qd_r[QDIV_STEPS].sd.weight) - $signed({2'b00, delta});
    end
    if (res[35:31] == 5'b00000 || res[35:31] == 5'b11111) begin
      out_nxt.weight_out = res[31:0];
    end else if (res[35]) begin
      out_nxt.weight_out = 32'sh8000_0000;
    end else begin
      out_nxt.weight_out = 32'sh7FFF_FFFF;
    end
    out_nxt.element_index = qd_r[QDIV_STEPS].sd.idx;
    out_nxt.step_end      = qd_r[QDIV_STEPS].sd.last;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= qd_r[QDIV_STEPS].sd.valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

// ----- rtl/adam_optimizer_update.sv -----
// adam_optimizer_update: top level with configuration registers, front end and
// back end; uses aou_pkg, aou_front and aou_back
`default_nettype none

// Streams one weight and gradient per beat, elements 0..param_count-1 of each
// optimizer step (count 0 acts as 1, above 1024 as 1024), and returns the
// updated weight with its position and an end of step flag. One beat enters
// per cycle while in_stall is low; results pass the pipelined bias correction
// dividers (72 stages), the square root (52 stages) and the step divider (40
// stages). The moment memories are read at issue and rewritten from stage s2,
// so an element waits while an older one of its index is in s1 or s2, which
// slows param_count 1 and 2. After reset both moment memories are cleared, all
// 1024 entries, during which in_stall is high; configuration writes are
// taken throughout and belong only to idle periods.
module adam_optimizer_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [aou_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [aou_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aou_pkg::aou_in_t                    in_payload,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aou_pkg::aou_out_t                   out_payload
);
  import aou_pkg::*;

  aou_cfg_t  cfg_r;
  aou_head_t head;
  aou_ctl_t  ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.param_count    <= CNT_W'(1024);
      cfg_r.step_rate      <= 24'd16777;
      cfg_r.first_decay    <= 24'd15099494;
      cfg_r.second_decay   <= 24'd16760439;
      cfg_r.stability_term <= 32'd43;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PARAM_COUNT:    cfg_r.param_count    <= cfg_wdata[CNT_W-1:0];
        REG_STEP_RATE:      cfg_r.step_rate      <= cfg_wdata[23:0];
        REG_FIRST_DECAY:    cfg_r.first_decay    <= cfg_wdata[23:0];
        REG_SECOND_DECAY:   cfg_r.second_decay   <= cfg_wdata[23:0];
        REG_STABILITY_TERM: cfg_r.stability_term <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  aou_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .head       (head),
    .ctl        (ctl)
  );

  aou_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

  // back end only takes from a non-empty queue
  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> head.valid)
    else $error("queue popped while empty");

  // nothing is queued while the memories clear
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clearing |-> !head.valid)
    else $error("element queued during memory clearing");

  // end of step flag agrees with the position and the step length
  a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.step_end |->
      (CNT_W'(out_payload.element_index) + CNT_W'(1)) >= eff_count(cfg_r.param_count))
    else $error("step end before the last element");

  a_mid_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.step_end |->
      (CNT_W'(out_payload.element_index) + CNT_W'(1)) < eff_count(cfg_r.param_count))
    else $error("missing step end on the last element");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for the adam optimizer update block
// drives weight and gradient beats, predicts every result and compares; needs aou_pkg
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import aou_pkg::*;

  localparam int N_RANDOM = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 400;
  // index beyond the register list
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  aou_in_t in_payload;
  logic out_valid;
  logic out_stall;
  aou_out_t out_payload;

  adam_optimizer_update dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_payload(in_payload), .out_valid(out_valid), .out_stall(out_stall),
    .out_payload(out_payload)
  );

  // predictor state
  logic [10:0] pc_r;
  logic [23:0] lr_r, b1_r, b2_r;
  logic [31:0] eps_r;
  logic signed [31:0] m_mem [MAX_PARAMS];
  logic [47:0] v_mem [MAX_PARAMS];
  logic [31:0] step_num;
  logic [24:0] pow1, pow2;
  logic [9:0] elem_cnt;

  aou_out_t weight_q[$];
  int mismatches;
  int cycles;
  int stall_left;
  bit quiet_tail;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt128(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // compute one updated weight and advance predictor state
  function automatic aou_out_t adam_predict(input aou_in_t it);
    logic [10:0] cnt;
    logic [9:0] idx;
    logic signed [63:0] macc, g, w, r;
    logic signed [31:0] m;
    logic [63:0] ga, gsq, vo, c2, v, bc1, bc2, ma, mhat, vq, vr, vhat, den, delta;
    logic [127:0] num, qt;
    aou_out_t res;
    cnt = (pc_r == 0) ? 11'd1 : (pc_r > MAX_PARAMS ? 11'(MAX_PARAMS) : pc_r);
    idx = elem_cnt;
    w = 64'(it.weight_in);
    g = 64'(it.gradient);
    if (idx == 0) begin
      step_num = step_num + 1;
      pow1 = 25'((64'(pow1) * 64'(b1_r)) >> 24);
      pow2 = 25'((64'(pow2) * 64'(b2_r)) >> 24);
    end
    macc = $signed({40'd0, b1_r}) * 64'(m_mem[idx])
         + $signed(64'(ONE_Q24) - {40'd0, b1_r}) * g;
    m = 32'(macc >>> 24);
    m_mem[idx] = m;
    ga = (g < 0) ? 64'(-g) : 64'(g);
    gsq = (ga * ga) >> 8;
    if (gsq > 64'hFFFF_FFFF_FFFF) gsq = 64'hFFFF_FFFF_FFFF;
    vo = 64'(v_mem[idx]);
    c2 = 64'(ONE_Q24) - 64'(b2_r);
    v = 64'(b2_r) * (vo >> 24) + c2 * (gsq >> 24)
      + ((64'(b2_r) * (vo & 64'hFF_FFFF) + c2 * (gsq & 64'hFF_FFFF)) >> 24);
    if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
    v_mem[idx] = 48'(v);
    bc1 = 64'(ONE_Q24) - 64'(pow1);
    bc2 = 64'(ONE_Q24) - 64'(pow2);
    if (bc1 == 0 || bc1 > 64'(ONE_Q24)) bc1 = 1;
    if (bc2 == 0 || bc2 > 64'(ONE_Q24)) bc2 = 1;
    ma = (m < 0) ? 64'(-64'(m)) : 64'(m);
    mhat = (ma << 24) / bc1;
    vq = v / bc2;
    vr = v % bc2;
    vhat = (vq >= (64'd1 << 40)) ? '1 : (vq << 24) + ((vr << 24) / bc2);
    den = isqrt128({64'd0, vhat} << 40) + 64'(eps_r);
    num = ({104'd0, lr_r} * {64'd0, mhat}) << 8;
    if (den == 0) begin
      delta = (num != 0) ? 64'(DELTA_CAP) : 0;
    end else begin
      qt = num / {64'd0, den};
      delta = (qt > 128'(DELTA_CAP)) ? 64'(DELTA_CAP) : qt[63:0];
    end
    r = (m < 0) ? w + $signed(delta) : w - $signed(delta);
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    res.weight_out = 32'(r);
    res.element_index = idx;
    res.step_end = (11'(idx) + 1 >= cnt);
    elem_cnt = res.step_end ? 10'd0 : idx + 1;
    return res;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    aou_out_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (weight_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_payload);
        end else begin
          exp_r = weight_q.pop_front();
          if (out_payload !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected w=%h i=%0d e=%b, got w=%h i=%0d e=%b",
                       exp_r.weight_out, exp_r.element_index, exp_r.step_end,
                       out_payload.weight_out, out_payload.element_index,
                       out_payload.step_end);
          end
        end
      end
      // random stall bursts, none during the quiet tail
      if (quiet_tail || stall_left == 0) begin
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          out_stall <= 1'b1;
          stall_left <= int'($urandom_range(1, 4)) - 1;
        end else begin
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end
    end
  end

  // send one beat, with optional preceding idle burst
  task automatic send_beat(input aou_in_t it, input bit check_it, input aou_out_t typed);
    aou_out_t p;
    cfg_we <= 1'b0;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = adam_predict(it);
    if (check_it) p = typed;
    weight_q.push_back(p);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] ix, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_wdata <= val;
    @(posedge clk);
    case (ix)
      REG_PARAM_COUNT: pc_r = val[10:0];
      REG_STEP_RATE: lr_r = val[23:0];
      REG_FIRST_DECAY: b1_r = val[23:0];
      REG_SECOND_DECAY: b2_r = val[23:0];
      REG_STABILITY_TERM: eps_r = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  typedef struct {
    logic [31:0] w;
    logic [31:0] g;
    bit typed;
    aou_out_t res;
  } stim_row_t;

  // directed rows; with zero gradient and fresh moments the weight passes unchanged
  stim_row_t dir_tab [] = '{
    '{32'h0001_0000, 32'h0, 1'b1, '{32'h0001_0000, 10'd0, 1'b1}},
    '{32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h7FFF_FFFF, 10'd0, 1'b1}},
    '{32'h8000_0000, 32'h0, 1'b1, '{32'h8000_0000, 10'd0, 1'b1}},
    '{32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'h0000_0000, 32'h8000_0000, 1'b0, '0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'h1234_5678, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_0000, 32'h0000_0001, 1'b0, '0},
    '{32'h0000_8000, 32'h0001_0000, 1'b0, '0}
  };

  initial begin
    int n_sent;
    aou_in_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_payload = '0;
    quiet_tail = 1'b0;
    pc_r = 11'd1024; lr_r = 24'd16777; b1_r = 24'd15099494;
    b2_r = 24'd16760439; eps_r = 32'd43;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      m_mem[i] = '0;
      v_mem[i] = '0;
    end
    step_num = '0; pow1 = ONE_Q24; pow2 = ONE_Q24; elem_cnt = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: count zero acts as one element per step
    cfg_write(REG_PARAM_COUNT, 32'd0);
    foreach (dir_tab[i]) begin
      it.weight_in = dir_tab[i].w;
      it.gradient = dir_tab[i].g;
      send_beat(it, dir_tab[i].typed, dir_tab[i].res);
    end
    drain();

    // directed: extremes of rates, zero epsilon and zero root, oversized count
    cfg_write(REG_STEP_RATE, 32'hFF_FFFF);
    cfg_write(REG_FIRST_DECAY, 32'd0);
    cfg_write(REG_SECOND_DECAY, 32'hFF_FFFF);
    cfg_write(REG_STABILITY_TERM, 32'd0);
    cfg_write(REG_PARAM_COUNT, 32'd2047);
    cfg_write(REG_NONE, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) begin
      it.weight_in = rand_word();
      it.gradient = (i < 2) ? 32'h0 : rand_word();
      send_beat(it, 1'b0, '0);
    end
    drain();
    cfg_write(REG_STABILITY_TERM, 32'hFFFF_FFFF);
    cfg_write(REG_FIRST_DECAY, 32'hFF_FFFF);
    cfg_write(REG_SECOND_DECAY, 32'd0);
    cfg_write(REG_STEP_RATE, 32'd0);
    for (int i = 0; i < 4; i++) begin
      it.weight_in = rand_word();
      it.gradient = rand_word();
      send_beat(it, 1'b0, '0);
    end
    drain();

    // random phases with varied settings, small counts mostly
    n_sent = 0;
    for (int ph = 0; n_sent < N_RANDOM; ph++) begin
      cfg_write(REG_PARAM_COUNT, (ph % 4 == 3) ? 32'($urandom_range(0, 1100))
                                               : 32'($urandom_range(1, 9)));
      cfg_write(REG_STEP_RATE, $urandom_range(0, 3) == 0 ? 32'($urandom) & 32'hFF_FFFF
                                                         : 32'($urandom_range(1000, 70000)));
      cfg_write(REG_FIRST_DECAY, $urandom_range(0, 3) == 0 ? 32'($urandom) & 32'hFF_FFFF
                                                           : 32'd15099494);
      cfg_write(REG_SECOND_DECAY, $urandom_range(0, 3) == 0 ? 32'($urandom) & 32'hFF_FFFF
                                                            : 32'd16760439);
      cfg_write(REG_STABILITY_TERM, $urandom_range(0, 3) == 0 ? 32'($urandom)
                                                              : 32'($urandom_range(0, 100)));
      // beats of the phase; on some phases a changed count follows after the drain
      for (int k = 0; k < 60 && n_sent < N_RANDOM; k++) begin
        if (n_sent > N_RANDOM - 80) quiet_tail = 1'b1;
        it.weight_in = rand_word();
        it.gradient = rand_word();
        send_beat(it, 1'b0, '0);
        n_sent++;
      end
      drain();
      if (ph % 3 == 1) begin
        cfg_write(REG_PARAM_COUNT, 32'($urandom_range(1, 5)));
        for (int k = 0; k < 10; k++) begin
          it.weight_in = rand_word();
          it.gradient = rand_word();
          send_beat(it, 1'b0, '0);
        end
        drain();
      end
    end

    if (mismatches == 0 && weight_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/aou_pkg.sv
rtl/aou_ram.sv
rtl/aou_front.sv
rtl/aou_back.sv
rtl/adam_optimizer_update.sv
test/testbench.sv
